// ===== rtl/core/idfifo_pkg.sv =====
// Shared types and codes for the id-tagged queue with remove-by-id.
// No dependencies; used by idfifo_cell and id_tagged_fifo_with_remove.

package idfifo_pkg;

   localparam int OpW     = 3;
   localparam int IdW     = 16;
   localparam int RefW    = 16;
   localparam int TimeW   = 32;
   localparam int StatusW = 2;
   localparam int CountOutW = 5;

   localparam logic [OpW-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OpW-1:0] OP_LOAD    = 3'd1;
   localparam logic [OpW-1:0] OP_DEQUEUE = 3'd2;
   localparam logic [OpW-1:0] OP_REMOVE  = 3'd3;
   localparam logic [OpW-1:0] OP_PEEK    = 3'd4;

   localparam logic [StatusW-1:0] ST_OK       = 2'd0;
   localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [StatusW-1:0] ST_FULL     = 2'd2;

   // One stored entry
   typedef struct packed {
      logic [TimeW-1:0] time_stamp;
      logic [RefW-1:0]  influencer_ref;
      logic [RefW-1:0]  campaign_ref;
      logic [RefW-1:0]  brand_ref;
      logic [RefW-1:0]  campaign_number;
      logic [IdW-1:0]   id;
   } entry_type;

   // Request beat, last field (op) in the low bits
   typedef struct packed {
      logic [4:0]       pad;
      logic [TimeW-1:0] time_stamp;
      logic [RefW-1:0]  influencer_ref;
      logic [RefW-1:0]  campaign_ref;
      logic [RefW-1:0]  brand_ref;
      logic [RefW-1:0]  campaign_number;
      logic [IdW-1:0]   given_id;
      logic [OpW-1:0]   op;
   } req_type;

   // Response beat, last field (status) in the low bits
   typedef struct packed {
      logic                 empty_res;
      logic [CountOutW-1:0] count;
      logic [TimeW-1:0]     out_time;
      logic [RefW-1:0]      out_influencer;
      logic [RefW-1:0]      out_campaign_ref;
      logic [RefW-1:0]      out_brand;
      logic [RefW-1:0]      out_campaign;
      logic [IdW-1:0]       out_id;
      logic [StatusW-1:0]   status;
   } rsp_type;

   // Per-cycle controls broadcast to every cell
   typedef struct packed {
      logic shift_all;   // dequeue: every cell takes its neighbor
      logic shift_tail;  // remove: cells from the hit onward take their neighbor
   } cell_ctrl_type;

endpackage

// ===== rtl/core/idfifo_cell.sv =====
// One slot of the queue: holds an entry, compares its id, shifts toward the front.
// Depends on idfifo_pkg.

module idfifo_cell
   import idfifo_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          take_new,
   input  entry_type     new_entry,
   input  entry_type     next_entry,
   input  logic [IdW-1:0] given_id,
   input  logic          match_prev,
   output logic          match_out,
   output logic          hit,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      id_eq;

   assign id_eq     = occupied && (entry_ff.id == given_id);
   assign hit       = id_eq && !match_prev;
   assign match_out = match_prev || id_eq;
   assign entry     = entry_ff;

   always_comb begin
      priority if (take_new) begin
         entry_in = new_entry;
      end else if (ctrl.shift_all || (ctrl.shift_tail && match_out)) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/core/id_tagged_fifo_with_remove.sv =====
// Top level of the id-tagged queue with remove-by-id.
// Depends on idfifo_pkg and idfifo_cell.
//
// Usage:
//   req_* carries one command per beat: op, given_id and the fields of a
//   new entry. rsp_* returns exactly one result beat per command: status,
//   the entry concerned, and count / empty after the command.
//   Ops: enqueue (auto id from a saturating counter), load (given id, lifts
//   the counter), dequeue, remove by id (first match from the front, gap
//   closed), peek. Codes 5..7 do nothing and report ok.
// Structure:
//   A row of QUEUE_DEPTH cells, front at cell 0. A match chain from the front
//   lets only the first id match hit; dequeue or remove shifts entries forward.
// Timing:
//   One command per cycle while the output is not stalled; the result appears
//   in the cycle after the request beat, from a single output register. The id compare chain sets the path.
// Reset:
//   Synchronous, active high. Clears count, id counter and rsp_tvalid;
//   entry storage is not cleared (slots at or above count are never read).
// Stall:
//   While a result waits on rsp_tready low, req_tready is low; a new request
//   is taken in the same cycle the waiting result is taken.

module id_tagged_fifo_with_remove
   import idfifo_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[2:0], given_id[18:3], campaign_number[34:19], brand_ref[50:35],
   // campaign_ref[66:51], influencer_ref[82:67], time_stamp[114:83], zero pad
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], out_id[17:2], out_campaign[33:18], out_brand[49:34],
   // out_campaign_ref[65:50], out_influencer[81:66], out_time[113:82],
   // count[118:114], empty_res[119]
   output logic [119:0] rsp_tdata
);

   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   req_type req;
   assign req = req_type'(req_tdata);

   // control state
   logic [CountW-1:0] count_ff, count_in;
   logic [IdW-1:0]    id_counter_ff, id_counter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic accept;
   logic full, empty;
   logic is_enq, is_load, is_deq, is_rem, is_peek;
   logic do_write;
   logic any_hit;
   logic [IdW-1:0] new_id;

   entry_type     new_entry;
   entry_type     hit_entry;
   cell_ctrl_type ctrl;

   entry_type                cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   cell_hit;
   logic [QUEUE_DEPTH:0]     match_chain;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = (count_ff == CountW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   assign is_enq  = (req.op == OP_ENQUEUE);
   assign is_load = (req.op == OP_LOAD);
   assign is_deq  = (req.op == OP_DEQUEUE);
   assign is_rem  = (req.op == OP_REMOVE);
   assign is_peek = (req.op == OP_PEEK);

   assign do_write = accept && (is_enq || is_load) && !full;

   // saturating auto id, or the given id for a load
   always_comb begin
      id_counter_in = id_counter_ff;
      new_id        = req.given_id;
      if (is_enq) begin
         new_id = (id_counter_ff != '1) ? id_counter_ff + 1'b1 : id_counter_ff;
         if (do_write) id_counter_in = new_id;
      end else if (do_write && (req.given_id > id_counter_ff)) begin
         id_counter_in = req.given_id;
      end
   end

   always_comb begin
      new_entry.id              = new_id;
      new_entry.campaign_number = req.campaign_number;
      new_entry.brand_ref       = req.brand_ref;
      new_entry.campaign_ref    = req.campaign_ref;
      new_entry.influencer_ref  = req.influencer_ref;
      new_entry.time_stamp      = req.time_stamp;
   end

   assign ctrl.shift_all  = accept && is_deq && !empty;
   assign ctrl.shift_tail = accept && is_rem;

   // cell row, front at index 0
   assign match_chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type next_entry;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      idfifo_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CountW'(i) < count_ff),
         .take_new   (do_write && (count_ff == CountW'(i))),
         .new_entry  (new_entry),
         .next_entry (next_entry),
         .given_id   (req.given_id),
         .match_prev (match_chain[i]),
         .match_out  (match_chain[i+1]),
         .hit        (cell_hit[i]),
         .entry      (cell_entry[i])
      );
   end

   assign any_hit = match_chain[QUEUE_DEPTH];

   // at most one cell hits, so an OR of gated entries selects it
   always_comb begin
      hit_entry = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_entry = hit_entry | (cell_hit[i] ? cell_entry[i] : '0);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_write) begin
         count_in = count_ff + 1'b1;
      end else if (accept && ((is_deq && !empty) || (is_rem && any_hit))) begin
         count_in = count_ff - 1'b1;
      end
   end

   // result beat
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ST_OK;
      priority if (is_enq || is_load) begin
         if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.out_id = new_id;
         end
      end else if (is_deq || is_peek) begin
         if (empty) begin
            rsp_in.status = ST_NOTFOUND;
         end else begin
            rsp_in.out_id           = cell_entry[0].id;
            rsp_in.out_campaign     = cell_entry[0].campaign_number;
            rsp_in.out_brand        = cell_entry[0].brand_ref;
            rsp_in.out_campaign_ref = cell_entry[0].campaign_ref;
            rsp_in.out_influencer   = cell_entry[0].influencer_ref;
            rsp_in.out_time         = cell_entry[0].time_stamp;
         end
      end else if (is_rem) begin
         if (!any_hit) begin
            rsp_in.status = ST_NOTFOUND;
         end else begin
            rsp_in.out_id           = hit_entry.id;
            rsp_in.out_campaign     = hit_entry.campaign_number;
            rsp_in.out_brand        = hit_entry.brand_ref;
            rsp_in.out_campaign_ref = hit_entry.campaign_ref;
            rsp_in.out_influencer   = hit_entry.influencer_ref;
            rsp_in.out_time         = hit_entry.time_stamp;
         end
      end else begin
         rsp_in.status = ST_OK;
      end
      rsp_in.count     = CountOutW'(count_in);
      rsp_in.empty_res = (count_in == '0);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         id_counter_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            count_ff      <= count_in;
            id_counter_ff <= id_counter_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_hit))
      else $error("more than one cell hit");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      do_write |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not grow after a write");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

endmodule

// ===== dv/idfifo_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the id-tagged queue: watches req/rsp beats, predicts each result.
// Depends on idfifo_pkg; instantiated by tb_id_tagged_fifo_with_remove.

module idfifo_scoreboard
   import idfifo_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [119:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,
   output int           mismatch_count,
   output int           results_owed
);

   entry_type      queued_entries[$];
   logic [IdW-1:0] id_counter_model;
   rsp_type        owed_rsp[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: rsp %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic rsp_type with_entry(input rsp_type r, input entry_type e);
      rsp_type o;
      o = r;
      o.out_id           = e.id;
      o.out_campaign     = e.campaign_number;
      o.out_brand        = e.brand_ref;
      o.out_campaign_ref = e.campaign_ref;
      o.out_influencer   = e.influencer_ref;
      o.out_time         = e.time_stamp;
      return o;
   endfunction

   // Applies one command to the queue image and returns the result it causes
   function automatic rsp_type serve_command(input req_type c);
      rsp_type   r;
      entry_type e;
      int        hit;
      r   = '0;
      hit = -1;
      case (c.op)
         OP_ENQUEUE, OP_LOAD: begin
            if (queued_entries.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (c.op == OP_ENQUEUE) begin
                  if (id_counter_model != '1) id_counter_model++;
                  e.id = id_counter_model;
               end else begin
                  e.id = c.given_id;
                  if (c.given_id > id_counter_model) id_counter_model = c.given_id;
               end
               e.campaign_number = c.campaign_number;
               e.brand_ref       = c.brand_ref;
               e.campaign_ref    = c.campaign_ref;
               e.influencer_ref  = c.influencer_ref;
               e.time_stamp      = c.time_stamp;
               queued_entries.push_back(e);
               r.out_id = e.id;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (queued_entries.size() == 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               r = with_entry(r, queued_entries[0]);
               if (c.op == OP_DEQUEUE) void'(queued_entries.pop_front());
            end
         end
         OP_REMOVE: begin
            // first match from the front wins
            for (int i = 0; i < queued_entries.size(); i++)
               if (hit < 0 && queued_entries[i].id == c.given_id) hit = i;
            if (hit < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               r = with_entry(r, queued_entries[hit]);
               queued_entries.delete(hit);
            end
         end
         default: ;
      endcase
      r.count     = CountOutW'(queued_entries.size());
      r.empty_res = (queued_entries.size() == 0);
      return r;
   endfunction

   task automatic compare_result(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.out_id !== want.out_id)
         report_mismatch("out_id", 32'(got.out_id), 32'(want.out_id));
      if (got.out_campaign !== want.out_campaign)
         report_mismatch("out_campaign", 32'(got.out_campaign), 32'(want.out_campaign));
      if (got.out_brand !== want.out_brand)
         report_mismatch("out_brand", 32'(got.out_brand), 32'(want.out_brand));
      if (got.out_campaign_ref !== want.out_campaign_ref)
         report_mismatch("out_campaign_ref", 32'(got.out_campaign_ref),
                         32'(want.out_campaign_ref));
      if (got.out_influencer !== want.out_influencer)
         report_mismatch("out_influencer", 32'(got.out_influencer),
                         32'(want.out_influencer));
      if (got.out_time !== want.out_time)
         report_mismatch("out_time", got.out_time, want.out_time);
      if (got.count !== want.count)
         report_mismatch("count", 32'(got.count), 32'(want.count));
      if (got.empty_res !== want.empty_res)
         report_mismatch("empty_res", 32'(got.empty_res), 32'(want.empty_res));
   endtask

   always @(posedge clock) begin : watch_beats
      rsp_type want;
      if (reset) begin
         queued_entries.delete();
         owed_rsp.delete();
         id_counter_model = '0;
         mismatch_count   = 0;
      end else begin
         // result side first: a beat taken now belongs to an earlier command
         if (rsp_tvalid && rsp_tready) begin
            if (owed_rsp.size() == 0) begin
               report_mismatch("beat with nothing owed", rsp_tdata[31:0], '0);
            end else begin
               want = owed_rsp.pop_front();
               compare_result(rsp_type'(rsp_tdata), want);
            end
         end
         if (req_tvalid && req_tready)
            owed_rsp.push_back(serve_command(req_type'(req_tdata[$bits(req_type)-1:0])));
      end
      results_owed <= owed_rsp.size();
   end

endmodule

// ===== dv/tb_id_tagged_fifo_with_remove.sv =====
`timescale 1ns / 100ps
// Top of the testbench for id_tagged_fifo_with_remove: clock, reset, stimulus, verdict.
// Depends on idfifo_pkg, the block and idfifo_scoreboard (which does all checking).

module tb_id_tagged_fifo_with_remove;
   import idfifo_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int CLK_HALF      = 10;    // 20 ns period
   localparam int RESET_CYCLES  = 8;
   localparam int RANDOM_BEATS  = 750;
   localparam int PHASES        = 3;
   localparam int SETTLE_CYCLES = 4;     // result register is one stage deep
   localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
   localparam int RECENT_KEEP   = 24;

   // op codes the block treats as no-ops
   localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OpW-1:0] OP_SPARE_LAST  = 3'd7;

   // bias of a burst of random commands
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // op, given_id, campaign_number, brand_ref, campaign_ref, influencer_ref,
   // time_stamp, zero pad (lowest bits first)
   logic [119:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // status, out_id, out_campaign, out_brand, out_campaign_ref, out_influencer,
   // out_time, count, empty_res (lowest bits first)
   logic [119:0] rsp_tdata;

   int mismatch_count;
   int results_owed;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   // Rough image of ids handed out, only to aim loads and removes at
   // live entries; the scoreboard holds the exact state.
   int id_guess;
   int recent_ids[$];

   id_tagged_fifo_with_remove #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   idfifo_scoreboard #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // Receiver backpressure, redrawn every cycle on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: too long without a beat on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Command with a random payload for the new-entry fields
   function automatic req_type random_command(input logic [OpW-1:0] op,
                                              input logic [IdW-1:0] gid);
      req_type c;
      c                 = '0;
      c.op              = op;
      c.given_id        = gid;
      c.campaign_number = RefW'($urandom);
      c.brand_ref       = RefW'($urandom);
      c.campaign_ref    = RefW'($urandom);
      c.influencer_ref  = RefW'($urandom);
      c.time_stamp      = $urandom;
      return c;
   endfunction

   // Command with every payload bit set to fill_bit
   function automatic req_type flat_command(input logic [OpW-1:0] op,
                                            input logic [IdW-1:0] gid,
                                            input logic fill_bit);
      req_type c;
      c          = fill_bit ? '1 : '0;
      c.pad      = '0;
      c.op       = op;
      c.given_id = gid;
      return c;
   endfunction

   function automatic logic [OpW-1:0] pick_op(input mix_type m);
      int roll;
      roll = $urandom_range(99);
      case (m)
         MIX_FILL: begin
            if (roll < 45)      return OP_ENQUEUE;
            else if (roll < 75) return OP_LOAD;
            else if (roll < 85) return OP_PEEK;
            else if (roll < 93) return OP_DEQUEUE;
            else if (roll < 98) return OP_REMOVE;
         end
         MIX_DRAIN: begin
            if (roll < 10)      return OP_ENQUEUE;
            else if (roll < 20) return OP_LOAD;
            else if (roll < 50) return OP_DEQUEUE;
            else if (roll < 85) return OP_REMOVE;
            else if (roll < 95) return OP_PEEK;
         end
         default: begin
            if (roll < 25)      return OP_ENQUEUE;
            else if (roll < 40) return OP_LOAD;
            else if (roll < 60) return OP_DEQUEUE;
            else if (roll < 80) return OP_REMOVE;
            else if (roll < 95) return OP_PEEK;
         end
      endcase
      return OpW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
   endfunction

   // Loads mostly reuse or trail the counter so it stays small until the end
   function automatic logic [IdW-1:0] pick_load_id();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40 && recent_ids.size() > 0)
         return IdW'(recent_ids[$urandom_range(recent_ids.size() - 1)]);
      else if (roll < 85)
         return IdW'($urandom_range(0, id_guess + 4));
      return IdW'(id_guess + $urandom_range(1, 3));
   endfunction

   // Removes mostly aim at a recent id; the rest use a full-range random id
   function automatic logic [IdW-1:0] pick_remove_id();
      if ($urandom_range(99) < 75 && recent_ids.size() > 0)
         return IdW'(recent_ids[$urandom_range(recent_ids.size() - 1)]);
      return IdW'($urandom);
   endfunction

   // Drives one request beat; entered and left on a falling edge.
   // tvalid stays high across back-to-back beats (one write per step).
   task automatic send_beat(input req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      if (c.op == OP_ENQUEUE) begin
         if (id_guess < 65535) id_guess++;
         recent_ids.push_back(id_guess);
      end else if (c.op == OP_LOAD) begin
         if (c.given_id > id_guess) id_guess = c.given_id;
         recent_ids.push_back(c.given_id);
      end
      if (recent_ids.size() > RECENT_KEEP) void'(recent_ids.pop_front());
      @(negedge clock);
   endtask

   // Holds the sender off until every owed result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input mix_type m);
      logic [OpW-1:0] op;
      logic [IdW-1:0] gid;
      op  = pick_op(m);
      gid = IdW'($urandom);
      if (op == OP_LOAD)        gid = pick_load_id();
      else if (op == OP_REMOVE) gid = pick_remove_id();
      send_beat(random_command(op, gid));
   endtask

   initial begin : stimulus
      int      left;
      int      burst;
      mix_type mix;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      send_idle_pct = 15;
      recv_idle_pct = 47;
      id_guess      = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: empty queue, no-op codes, extremes, full, duplicates
      send_beat(random_command(OP_DEQUEUE, '0));
      send_beat(random_command(OP_PEEK, '0));
      send_beat(random_command(OP_REMOVE, '0));
      send_beat(random_command(OP_SPARE_FIRST, '1));
      send_beat(random_command(OP_SPARE_LAST, '0));
      send_beat(flat_command(OP_ENQUEUE, '0, 1'b0));   // id 1, all-zero payload
      send_beat(flat_command(OP_ENQUEUE, '1, 1'b1));   // id 2, all-one payload
      send_beat(random_command(OP_LOAD, '0));          // id 0, counter unchanged
      send_beat(random_command(OP_LOAD, IdW'(1)));     // duplicate of the front id
      repeat (QUEUE_DEPTH - 4) send_beat(random_command(OP_ENQUEUE, '0));
      send_beat(random_command(OP_ENQUEUE, '0));       // full
      send_beat(random_command(OP_LOAD, IdW'(7)));     // full, counter must hold
      send_beat(random_command(OP_PEEK, '0));
      send_beat(random_command(OP_REMOVE, IdW'(1)));   // front copy of the duplicate
      send_beat(random_command(OP_REMOVE, IdW'(1)));   // the later copy, gap closed
      send_beat(random_command(OP_REMOVE, IdW'(16'hBEEF)));  // miss
      send_beat(random_command(OP_DEQUEUE, '0));

      // --- random: three idle profiles, bursts biased to fill or drain
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin send_idle_pct = 15; recv_idle_pct = 47; end
            1: begin send_idle_pct = 47; recv_idle_pct = 15; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         left = RANDOM_BEATS / PHASES;
         while (left > 0) begin
            burst = $urandom_range(4, 24);
            if (burst > left) burst = left;
            mix = mix_type'($urandom_range(MIX_EVEN));
            repeat (burst) send_random(mix);
            left -= burst;
            if ($urandom_range(99) < 5) wait_drained();
         end
      end

      // --- directed, last: counter saturation (it never comes back down)
      repeat (QUEUE_DEPTH) send_beat(random_command(OP_DEQUEUE, '0));
      send_beat(random_command(OP_LOAD, IdW'(16'hFFFE)));
      send_beat(random_command(OP_ENQUEUE, '0));           // takes 0xFFFF
      send_beat(random_command(OP_ENQUEUE, '0));           // saturated, 0xFFFF again
      send_beat(random_command(OP_REMOVE, IdW'(16'hFFFF)));
      send_beat(random_command(OP_LOAD, IdW'(16'h8000)));  // counter stays
      send_beat(random_command(OP_ENQUEUE, '0));
      send_beat(random_command(OP_PEEK, '0));

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/idfifo_pkg.sv
rtl/core/idfifo_cell.sv
rtl/core/id_tagged_fifo_with_remove.sv
dv/idfifo_scoreboard.sv
dv/tb_id_tagged_fifo_with_remove.sv
